[sv/biq_pkg.sv]
// ----------------------------------------------------------------------------
// Biquad TDF-II package
// Shared types and constants for the multichannel biquad filter: coefficient
// register indexes, the delay row layout and the sequencer control word.
// ----------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned STATE_W    = 48;
  localparam int unsigned PROD_W     = COEF_W + SAMPLE_W;
  localparam int unsigned ACC_W      = 62;
  localparam int unsigned NUM_COEF   = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Coefficient register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

  // Reset value of b0 is 1.0 in Q4.28.
  localparam logic [COEF_W-1:0] B0_RESET = 32'h1000_0000;

  typedef logic [COEF_W-1:0] coef_arr_t [NUM_COEF];

  // One channel's delay pair, Q8.40 each.
  typedef struct packed {
    logic [STATE_W-1:0] d2;
    logic [STATE_W-1:0] d1;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MB1,
    ST_MB2,
    ST_MA1,
    ST_MA2,
    ST_FIN,
    ST_WB
  } state_e;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_B0X,
    MUL_B1X,
    MUL_B2X,
    MUL_A1Y,
    MUL_A2Y
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LD_D1,
    ACC_LD_D2,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    ACC2_HOLD,
    ACC2_LD,
    ACC2_SUB
  } acc2_op_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    acc2_op_e acc2_op;
    logic     y_ld;
    logic     wr_en;
    logic     out_ld;
  } ctrl_t;

endpackage

`default_nettype wire

[sv/biq_dmem.sv]
// ----------------------------------------------------------------------------
// Biquad delay memory
// One row of two delay words per channel. Registered read, single write
// port, and a valid bit per row so that unwritten rows read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_dmem #(
  parameter int unsigned NUM_CHANNELS = 2,
  parameter int unsigned AW           = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output biq_pkg::row_t        rd_row_o,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire biq_pkg::row_t   wr_row_i
);

  biq_pkg::row_t             mem [NUM_CHANNELS];
  biq_pkg::row_t             rdata_q;
  logic [NUM_CHANNELS-1:0]   valid_q;
  logic                      hit_q;

  // Storage and registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Valid bits are cleared by reset; a row becomes valid on its first write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = hit_q ? rdata_q : '0;

endmodule

`default_nettype wire

[sv/biq_mac.sv]
// ----------------------------------------------------------------------------
// Biquad multiply-accumulate unit
// One 32x24 signed multiplier with a product register, feeding two 62-bit
// accumulators, plus the rounding and saturation of the results.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_mac (
  input  wire logic                            clk_i,
  input  wire biq_pkg::ctrl_t                  ctrl_i,
  input  wire biq_pkg::coef_arr_t              coef_i,
  input  wire logic [biq_pkg::SAMPLE_W-1:0]    x_i,
  input  wire biq_pkg::row_t                   row_i,
  output logic      [biq_pkg::SAMPLE_W-1:0]    y_o,
  output logic      [biq_pkg::STATE_W-1:0]     n1_o,
  output logic      [biq_pkg::STATE_W-1:0]     n2_o
);

  localparam logic [biq_pkg::ACC_W-1:0] RND_Y = 62'h1 << 27;
  localparam logic [biq_pkg::ACC_W-1:0] RND_S = 62'h1 << 10;

  logic signed [biq_pkg::COEF_W-1:0]   coef_s;
  logic signed [biq_pkg::SAMPLE_W-1:0] opnd_s;
  logic signed [biq_pkg::PROD_W-1:0]   prod_d, prod_q;
  logic [biq_pkg::ACC_W-1:0]           p_ext, d1_ext, d2_ext;
  logic [biq_pkg::ACC_W-1:0]           acc_d, acc_q, acc2_d, acc2_q;
  logic [biq_pkg::SAMPLE_W-1:0]        y_d, y_q;

  // Rounded Q1.23 sample: acc / 2^28, clamped to 24 bits.
  function automatic logic [biq_pkg::SAMPLE_W-1:0] sat_sample(
    input logic [biq_pkg::ACC_W-1:0] a
  );
    logic fits;
    fits = (a[61:51] == {11{a[51]}});
    if (fits) begin
      return a[51:28];
    end else if (a[61]) begin
      return 24'h80_0000;
    end else begin
      return 24'h7F_FFFF;
    end
  endfunction

  // Rounded Q8.40 state: acc / 2^11, clamped to 48 bits.
  function automatic logic [biq_pkg::STATE_W-1:0] sat_state(
    input logic [biq_pkg::ACC_W-1:0] a
  );
    logic fits;
    fits = (a[61:58] == {4{a[58]}});
    if (fits) begin
      return a[58:11];
    end else if (a[61]) begin
      return {1'b1, 47'h0};
    end else begin
      return {1'b0, {47{1'b1}}};
    end
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctrl_i.mul_sel)
      biq_pkg::MUL_B0X: begin
        coef_s = coef_i[biq_pkg::CFG_B0];
        opnd_s = x_i;
      end
      biq_pkg::MUL_B1X: begin
        coef_s = coef_i[biq_pkg::CFG_B1];
        opnd_s = x_i;
      end
      biq_pkg::MUL_B2X: begin
        coef_s = coef_i[biq_pkg::CFG_B2];
        opnd_s = x_i;
      end
      biq_pkg::MUL_A1Y: begin
        coef_s = coef_i[biq_pkg::CFG_A1];
        opnd_s = y_q;
      end
      biq_pkg::MUL_A2Y: begin
        coef_s = coef_i[biq_pkg::CFG_A2];
        opnd_s = y_q;
      end
      default: begin
        coef_s = coef_i[biq_pkg::CFG_B0];
        opnd_s = x_i;
      end
    endcase
  end

  assign prod_d = coef_s * opnd_s;

  // Products and delay words aligned to the 2^-51 scale.
  assign p_ext  = {{(biq_pkg::ACC_W - biq_pkg::PROD_W){prod_q[biq_pkg::PROD_W-1]}}, prod_q};
  assign d1_ext = {{3{row_i.d1[biq_pkg::STATE_W-1]}}, row_i.d1, 11'b0};
  assign d2_ext = {{3{row_i.d2[biq_pkg::STATE_W-1]}}, row_i.d2, 11'b0};

  // Main accumulator: output sum, then the first delay update.
  always_comb begin
    case (ctrl_i.acc_op)
      biq_pkg::ACC_LD_D1: acc_d = d1_ext + RND_Y;
      biq_pkg::ACC_LD_D2: acc_d = d2_ext + RND_S + p_ext;
      biq_pkg::ACC_ADD:   acc_d = acc_q + p_ext;
      biq_pkg::ACC_SUB:   acc_d = acc_q - p_ext;
      default:            acc_d = acc_q;
    endcase
  end

  // Second accumulator: the second delay update.
  always_comb begin
    case (ctrl_i.acc2_op)
      biq_pkg::ACC2_LD:  acc2_d = RND_S + p_ext;
      biq_pkg::ACC2_SUB: acc2_d = acc2_q - p_ext;
      default:           acc2_d = acc2_q;
    endcase
  end

  assign y_d = ctrl_i.y_ld ? sat_sample(acc_q) : y_q;

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    acc2_q <= acc2_d;
    y_q    <= y_d;
  end

  assign y_o  = y_q;
  assign n1_o = sat_state(acc_q);
  assign n2_o = sat_state(acc2_q);

endmodule

`default_nettype wire

[sv/biq_seq.sv]
// ----------------------------------------------------------------------------
// Biquad sequencer
// Steps the shared multiply-accumulate unit through the three TDF-II
// equations for one word, then writes back state and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_seq (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_fire_i,
  input  wire logic     out_free_i,
  output logic          in_ready_o,
  output biq_pkg::ctrl_t ctrl_o
);

  biq_pkg::state_e state_d, state_q;

  // Next state.
  always_comb begin
    case (state_q)
      biq_pkg::ST_IDLE: state_d = in_fire_i ? biq_pkg::ST_LOAD : biq_pkg::ST_IDLE;
      biq_pkg::ST_LOAD: state_d = biq_pkg::ST_MB1;
      biq_pkg::ST_MB1:  state_d = biq_pkg::ST_MB2;
      biq_pkg::ST_MB2:  state_d = biq_pkg::ST_MA1;
      biq_pkg::ST_MA1:  state_d = biq_pkg::ST_MA2;
      biq_pkg::ST_MA2:  state_d = biq_pkg::ST_FIN;
      biq_pkg::ST_FIN:  state_d = biq_pkg::ST_WB;
      biq_pkg::ST_WB:   state_d = out_free_i ? biq_pkg::ST_IDLE : biq_pkg::ST_WB;
      default:          state_d = biq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= biq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control word for each step.
  always_comb begin
    ctrl_o.mul_sel = biq_pkg::MUL_B0X;
    ctrl_o.acc_op  = biq_pkg::ACC_HOLD;
    ctrl_o.acc2_op = biq_pkg::ACC2_HOLD;
    ctrl_o.y_ld    = 1'b0;
    ctrl_o.wr_en   = 1'b0;
    ctrl_o.out_ld  = 1'b0;
    in_ready_o     = 1'b0;
    case (state_q)
      biq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      biq_pkg::ST_LOAD: begin
        ctrl_o.mul_sel = biq_pkg::MUL_B0X;
        ctrl_o.acc_op  = biq_pkg::ACC_LD_D1;
      end
      biq_pkg::ST_MB1: begin
        ctrl_o.mul_sel = biq_pkg::MUL_B1X;
        ctrl_o.acc_op  = biq_pkg::ACC_ADD;
      end
      biq_pkg::ST_MB2: begin
        ctrl_o.mul_sel = biq_pkg::MUL_B2X;
        ctrl_o.acc_op  = biq_pkg::ACC_LD_D2;
        ctrl_o.y_ld    = 1'b1;
      end
      biq_pkg::ST_MA1: begin
        ctrl_o.mul_sel = biq_pkg::MUL_A1Y;
        ctrl_o.acc2_op = biq_pkg::ACC2_LD;
      end
      biq_pkg::ST_MA2: begin
        ctrl_o.mul_sel = biq_pkg::MUL_A2Y;
        ctrl_o.acc_op  = biq_pkg::ACC_SUB;
      end
      biq_pkg::ST_FIN: begin
        ctrl_o.acc2_op = biq_pkg::ACC2_SUB;
      end
      biq_pkg::ST_WB: begin
        ctrl_o.wr_en  = out_free_i;
        ctrl_o.out_ld = out_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/biquad_tdf2_filter.sv]
// ----------------------------------------------------------------------------
// Multichannel biquad filter, transposed direct form II
// y = b0*x + d1; d1 = b1*x - a1*y + d2; d2 = b2*x - a2*y, per channel,
// with round half up and saturation of output and state.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word                     Side data
//  s_axis    in   tdata[23:0] sample_in    tuser[0] channel_index
//  m_axis    out  tdata[23:0] sample_out   tuser[0] channel_out
//  cfg       in   cfg_data_i coefficient   cfg_idx_i b0,b1,b2,a1,a2
//
//  A word passes through the accept state, five multiply steps on the single
//  shared 32x24 multiplier, one last subtract and the write-back, which loads
//  the result into the output register.
//  The input is ready only while the sequencer is idle; a finished word
//  waits in the output register while the next word is taken in.
//  If the output register is full and not taken at write-back, the sequencer holds.
//  Reset clears the coefficients to b0 = 1.0 and all delay state to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_tdf2_filter #(
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [23:0]                       s_axis_tdata,  // [23:0] sample_in
  input  wire logic [0:0]                        s_axis_tuser,  // [0] channel_index
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [23:0]                       m_axis_tdata,  // [23:0] sample_out
  output logic      [0:0]                        m_axis_tuser,  // [0] channel_out
  // Coefficient write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [biq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [biq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  biq_pkg::coef_arr_t                coef_q;
  biq_pkg::ctrl_t                    ctrl;
  biq_pkg::row_t                     rd_row, wr_row;
  logic                              in_fire, out_free;
  logic [AW-1:0]                     rd_addr, addr_q;
  logic [biq_pkg::SAMPLE_W-1:0]      x_q, y;
  logic [biq_pkg::STATE_W-1:0]       n1, n2;
  logic                              ch_q;
  logic                              m_valid_q;
  logic [biq_pkg::SAMPLE_W-1:0]      m_data_q;
  logic                              m_user_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // With one channel every sample uses row zero.
  assign rd_addr = (NUM_CHANNELS > 1) ? AW'(s_axis_tuser[0]) : '0;

  // Coefficient registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[biq_pkg::CFG_B0] <= biq_pkg::B0_RESET;
      coef_q[biq_pkg::CFG_B1] <= '0;
      coef_q[biq_pkg::CFG_B2] <= '0;
      coef_q[biq_pkg::CFG_A1] <= '0;
      coef_q[biq_pkg::CFG_A2] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < biq_pkg::CFG_IDX_W'(biq_pkg::NUM_COEF))) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Input word held for the whole computation.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= s_axis_tdata;
      ch_q   <= s_axis_tuser[0];
      addr_q <= rd_addr;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.out_ld) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_ld) begin
      m_data_q <= y;
      m_user_q <= ch_q;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

  assign wr_row.d1 = n1;
  assign wr_row.d2 = n2;

  biq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  biq_dmem #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .AW           (AW)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row),
    .wr_en_i   (ctrl.wr_en),
    .wr_addr_i (addr_q),
    .wr_row_i  (wr_row)
  );

  biq_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .coef_i (coef_q),
    .x_i    (x_q),
    .row_i  (rd_row),
    .y_o    (y),
    .n1_o   (n1),
    .n2_o   (n2)
  );

endmodule

`default_nettype wire

[sv/biq_checker.sv]
// ----------------------------------------------------------------------------
// Biquad port checker
// Concurrent checks on the filter's stream ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // The input closes right after a word is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted word");

  // The input is still closed when the computation has reached write-back.
  a_busy_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> ##7 !s_axis_tready)
    else $error("input reopened before write-back");

  // A new result only appears from write-back, when the input is closed.
  a_result_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a computation");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind biquad_tdf2_filter biq_checker u_biq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
